// File: design/vts_pkg.sv
// Shared types and codes for the virtual-runtime tick scheduler.
package vts_pkg;

  localparam int WEIGHT_W = 8;
  localparam int RUN_W    = 9;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_INSERT = 2'd1;
  localparam logic [1:0] STATUS_BAD_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]          operation;
    logic [3:0]          proc_id;
    logic [WEIGHT_W-1:0] weight;
    logic [31:0]         start_vruntime;
  } vts_in_t;

  typedef struct packed {
    logic [3:0]  running_id;
    logic        switched;
    logic [31:0] min_vruntime;
    logic [31:0] tick_count;
    logic [4:0]  queued_count;
    logic [1:0]  status_code;
  } vts_out_t;

endpackage

// File: design/vts_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module vts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/vruntime_tick_scheduler.sv
// Fair-share scheduler: per-process table and vruntime-ordered wait queue in RAM.
// A kept-runner tick updates its table entry; an insert scans, shifts entries up and places;
// a remove scans and closes the gap; a switching tick reinserts the runner, then dequeues the
// head. One request at a time, the next taken the cycle after; a held result waits.
// Reset (synchronous, rst_n low) empties the queue and clears run counts at once
// via valid bits; process 0 runs with vruntime 0 and weight init_weight (1).
module vruntime_tick_scheduler #(
  parameter int MAX_PROCS     = 16,
  parameter int VRUNTIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vts_pkg::vts_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vts_pkg::vts_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vts_pkg::WEIGHT_W-1:0]    cfg_data
);

  import vts_pkg::*;

  localparam int PW = $clog2(MAX_PROCS);
  localparam int LW = $clog2(MAX_PROCS + 1);
  localparam int VW = VRUNTIME_BITS;

  typedef struct packed {
    logic [VW-1:0]       vr;
    logic [WEIGHT_W-1:0] wt;
    logic [RUN_W-1:0]    rc;
  } pent_t;

  typedef struct packed {
    logic [PW-1:0] id;
    logic [VW-1:0] vr;
  } qent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_INS, S_SCAN, S_UP, S_PLACE, S_DQ, S_DQD, S_DSET, S_DOWN, S_DONE
  } state_t;

  function automatic logic precedes(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW-1:0] d;
    d = a - b;
    return d[VW-1];
  endfunction

  state_t               state_r, state_nxt;
  logic [1:0]           op_r, op_nxt;
  logic [PW-1:0]        id_r, id_nxt;
  logic [WEIGHT_W-1:0]  wt_r, wt_nxt;
  logic [PW-1:0]        new_id_r, new_id_nxt;
  logic [VW-1:0]        new_vr_r, new_vr_nxt;
  logic [LW-1:0]        pos_r, pos_nxt;
  logic [LW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [LW-1:0]        chk_idx_r, chk_idx_nxt;
  logic                 chk_valid_r, chk_valid_nxt;
  logic                 issue_r, issue_nxt;
  logic [LW-1:0]        qlen_r, qlen_nxt;
  logic [PW-1:0]        running_r, running_nxt;
  logic [31:0]          ticks_r, ticks_nxt;
  logic [VW-1:0]        last_vr_r, last_vr_nxt;
  logic [MAX_PROCS-1:0] in_q_r, in_q_nxt;
  logic [MAX_PROCS-1:0] ent_valid_r, ent_valid_nxt;
  logic                 w0_cfg_r, w0_cfg_nxt;
  logic [WEIGHT_W-1:0]  init_weight_r, init_weight_nxt;
  logic                 switched_r, switched_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  vts_out_t             out_data_r, out_data_nxt;

  logic          p_we;
  logic [PW-1:0] p_waddr, p_raddr;
  pent_t         p_wdata, p_rdata;
  logic          q_we;
  logic [PW-1:0] q_waddr, q_raddr;
  qent_t         q_wdata, q_rdata;

  logic [PW-1:0]       in_id;
  logic                id_ok, ins_bad, rm_bad;
  logic [VW-1:0]       eff_vr, vr_inc;
  logic [RUN_W-1:0]    eff_rc, rc_inc;
  logic [WEIGHT_W-1:0] eff_wt;
  logic                hit;

  vts_ram #(.WIDTH($bits(pent_t)), .DEPTH(MAX_PROCS)) u_proc_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  vts_ram #(.WIDTH($bits(qent_t)), .DEPTH(MAX_PROCS)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_id   = PW'(in_data.proc_id);
  assign id_ok   = 32'(in_data.proc_id) < 32'(MAX_PROCS);
  assign ins_bad = !id_ok || in_q_r[in_id] || (in_id == running_r) ||
                   (qlen_r >= LW'(MAX_PROCS));
  assign rm_bad  = !id_ok || !in_q_r[in_id];

  // proc table read issued in the accept cycle, data used in the cycle after
  assign p_raddr = (in_data.operation == OP_TICK) ? running_r : in_id;

  // unwritten entries read vr and rc as zero; process 0 weight follows init_weight
  assign eff_vr = ent_valid_r[id_r] ? p_rdata.vr : '0;
  assign eff_rc = ent_valid_r[id_r] ? p_rdata.rc : '0;
  assign eff_wt = (id_r == '0 && w0_cfg_r) ? init_weight_r : p_rdata.wt;
  assign vr_inc = eff_vr + VW'(1);
  assign rc_inc = eff_rc + RUN_W'(1);

  assign hit = (op_r == OP_REMOVE) ? (q_rdata.id == id_r)
                                   : precedes(new_vr_r, q_rdata.vr);

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    id_nxt          = id_r;
    wt_nxt          = wt_r;
    new_id_nxt      = new_id_r;
    new_vr_nxt      = new_vr_r;
    pos_nxt         = pos_r;
    rd_idx_nxt      = rd_idx_r;
    chk_idx_nxt     = chk_idx_r;
    chk_valid_nxt   = 1'b0;
    issue_nxt       = issue_r;
    qlen_nxt        = qlen_r;
    running_nxt     = running_r;
    ticks_nxt       = ticks_r;
    last_vr_nxt     = last_vr_r;
    in_q_nxt        = in_q_r;
    ent_valid_nxt   = ent_valid_r;
    w0_cfg_nxt      = w0_cfg_r;
    init_weight_nxt = init_weight_r;
    switched_nxt    = switched_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;

    p_we    = 1'b0;
    p_waddr = id_r;
    p_wdata = '{vr: eff_vr, wt: eff_wt, rc: eff_rc};
    q_we    = 1'b0;
    q_waddr = PW'(pos_r);
    q_wdata = q_rdata;
    q_raddr = PW'(rd_idx_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_data.operation;
          id_nxt       = in_id;
          wt_nxt       = in_data.weight;
          new_id_nxt   = in_id;
          new_vr_nxt   = VW'(in_data.start_vruntime);
          switched_nxt = 1'b0;
          status_nxt   = STATUS_OK;
          rd_idx_nxt   = '0;
          case (in_data.operation)
            OP_TICK: begin
              ticks_nxt = ticks_r + 32'd1;
              id_nxt    = running_r;
              state_nxt = S_TICK;
            end
            OP_INSERT: begin
              if (ins_bad) begin
                status_nxt = STATUS_BAD_INSERT;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_INS;
              end
            end
            OP_REMOVE: begin
              if (rm_bad) begin
                status_nxt = STATUS_BAD_REMOVE;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_TICK: begin
        p_we              = 1'b1;
        ent_valid_nxt[id_r] = 1'b1;
        if (rc_inc > {1'b0, eff_wt}) begin
          p_wdata    = '{vr: vr_inc, wt: eff_wt, rc: '0};
          new_id_nxt = id_r;
          new_vr_nxt = vr_inc;
          if (qlen_r == '0) begin
            pos_nxt   = '0;
            state_nxt = S_PLACE;
          end else begin
            rd_idx_nxt = '0;
            state_nxt  = S_SCAN;
          end
        end else begin
          p_wdata   = '{vr: eff_vr, wt: eff_wt, rc: rc_inc};
          state_nxt = S_DONE;
        end
      end

      S_INS: begin
        // run count survives the insert
        p_we                = 1'b1;
        p_wdata             = '{vr: new_vr_r, wt: wt_r, rc: eff_rc};
        ent_valid_nxt[id_r] = 1'b1;
        if (id_r == '0) begin
          w0_cfg_nxt = 1'b0;
        end
        if (qlen_r == '0) begin
          pos_nxt   = '0;
          state_nxt = S_PLACE;
        end else begin
          rd_idx_nxt = '0;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (rd_idx_r < qlen_r) begin
          chk_valid_nxt = 1'b1;
          chk_idx_nxt   = rd_idx_r;
          rd_idx_nxt    = rd_idx_r + LW'(1);
        end
        if (chk_valid_r) begin
          if (hit) begin
            chk_valid_nxt = 1'b0;
            pos_nxt       = chk_idx_r;
            if (op_r == OP_REMOVE) begin
              in_q_nxt[id_r] = 1'b0;
              state_nxt      = S_DSET;
            end else begin
              rd_idx_nxt = qlen_r - LW'(1);
              issue_nxt  = 1'b1;
              state_nxt  = S_UP;
            end
          end else if (chk_idx_r == qlen_r - LW'(1)) begin
            chk_valid_nxt = 1'b0;
            if (op_r == OP_REMOVE) begin
              state_nxt = S_DONE;
            end else begin
              pos_nxt   = qlen_r;
              state_nxt = S_PLACE;
            end
          end
        end
      end

      S_UP: begin
        // open a slot at pos: move entries up, top first
        if (issue_r) begin
          chk_valid_nxt = 1'b1;
          chk_idx_nxt   = rd_idx_r;
          if (rd_idx_r == pos_r) begin
            issue_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r - LW'(1);
          end
        end
        if (chk_valid_r) begin
          q_we    = 1'b1;
          q_waddr = PW'(chk_idx_r + LW'(1));
          q_wdata = q_rdata;
          if (chk_idx_r == pos_r) begin
            chk_valid_nxt = 1'b0;
            state_nxt     = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        q_we                 = 1'b1;
        q_waddr              = PW'(pos_r);
        q_wdata              = '{id: new_id_r, vr: new_vr_r};
        qlen_nxt             = qlen_r + LW'(1);
        in_q_nxt[new_id_r]   = 1'b1;
        state_nxt            = (op_r == OP_TICK) ? S_DQ : S_DONE;
      end

      S_DQ: begin
        q_raddr   = '0;
        state_nxt = S_DQD;
      end

      S_DQD: begin
        running_nxt            = q_rdata.id;
        last_vr_nxt            = q_rdata.vr;
        in_q_nxt[q_rdata.id]   = 1'b0;
        switched_nxt           = 1'b1;
        pos_nxt                = '0;
        state_nxt              = S_DSET;
      end

      S_DSET: begin
        if (pos_r + LW'(1) >= qlen_r) begin
          qlen_nxt  = qlen_r - LW'(1);
          state_nxt = S_DONE;
        end else begin
          rd_idx_nxt = pos_r + LW'(1);
          issue_nxt  = 1'b1;
          state_nxt  = S_DOWN;
        end
      end

      S_DOWN: begin
        // close the gap at pos: move later entries down one place
        if (issue_r) begin
          chk_valid_nxt = 1'b1;
          chk_idx_nxt   = rd_idx_r;
          if (rd_idx_r == qlen_r - LW'(1)) begin
            issue_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + LW'(1);
          end
        end
        if (chk_valid_r) begin
          q_we    = 1'b1;
          q_waddr = PW'(chk_idx_r - LW'(1));
          q_wdata = q_rdata;
          if (chk_idx_r == qlen_r - LW'(1)) begin
            chk_valid_nxt = 1'b0;
            qlen_nxt      = qlen_r - LW'(1);
            state_nxt     = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.running_id   = 4'(running_r);
          out_data_nxt.switched     = switched_r;
          out_data_nxt.min_vruntime = 32'(last_vr_r);
          out_data_nxt.tick_count   = ticks_r;
          out_data_nxt.queued_count = 5'(qlen_r);
          out_data_nxt.status_code  = status_r;
          state_nxt                 = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (cfg_valid) begin
      init_weight_nxt = cfg_data;
      w0_cfg_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      chk_valid_r   <= 1'b0;
      issue_r       <= 1'b0;
      qlen_r        <= '0;
      running_r     <= '0;
      ticks_r       <= '0;
      last_vr_r     <= '0;
      in_q_r        <= '0;
      ent_valid_r   <= '0;
      w0_cfg_r      <= 1'b1;
      init_weight_r <= WEIGHT_W'(1);
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      chk_valid_r   <= chk_valid_nxt;
      issue_r       <= issue_nxt;
      qlen_r        <= qlen_nxt;
      running_r     <= running_nxt;
      ticks_r       <= ticks_nxt;
      last_vr_r     <= last_vr_nxt;
      in_q_r        <= in_q_nxt;
      ent_valid_r   <= ent_valid_nxt;
      w0_cfg_r      <= w0_cfg_nxt;
      init_weight_r <= init_weight_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    wt_r       <= wt_nxt;
    new_id_r   <= new_id_nxt;
    new_vr_r   <= new_vr_nxt;
    pos_r      <= pos_nxt;
    rd_idx_r   <= rd_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    switched_r <= switched_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
